// ===== hdl/crg_pkg.sv =====
// Shared constants and stage-enable type of the Catmull-Rom point and gradient unit.
package crg_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned T_FRAC_BITS_DEF = 16;

  typedef struct packed {
    logic mul;
    logic comb;
    logic sum;
    logic fin;
  } crg_en_t;

endpackage

// ===== hdl/crg_lane.sv =====
// One coordinate lane: weighted sum of four points, rounding and saturation.
module crg_lane #(
  parameter int unsigned COORD_WIDTH = crg_pkg::COORD_WIDTH_DEF,
  parameter int unsigned T_FRAC_BITS = crg_pkg::T_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  crg_pkg::crg_en_t              en_i,
  input  logic signed [COORD_WIDTH-1:0] coord_i  [4],
  input  logic signed [T_FRAC_BITS+3:0] weight_i [4],
  output logic signed [COORD_WIDTH-1:0] result_o,
  output logic                          clip_o
);
  import crg_pkg::*;

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned WW  = T_FRAC_BITS + 4;
  localparam int unsigned LW  = CW / 2;
  localparam int unsigned HW  = CW - LW;
  localparam int unsigned LPW = LW + 1 + WW;
  localparam int unsigned HPW = HW + WW;
  localparam int unsigned PW  = CW + WW;
  localparam int unsigned AW  = PW + 2;

  localparam logic signed [CW-1:0] MaxV = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MinV = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [AW-1:0] Half = AW'(1) << T_FRAC_BITS;

  logic signed [LPW-1:0] lo_p_d [4];
  logic signed [LPW-1:0] lo_p_q [4];
  logic signed [HPW-1:0] hi_p_d [4];
  logic signed [HPW-1:0] hi_p_q [4];
  logic signed [PW-1:0]  term_d [4];
  logic signed [PW-1:0]  term_q [4];
  logic signed [AW-1:0]  acc_d;
  logic signed [AW-1:0]  acc_q;
  logic signed [AW-1:0]  shifted;
  logic signed [CW-1:0]  result_d;
  logic signed [CW-1:0]  result_q;
  logic                  clip_d;
  logic                  clip_q;
  logic [AW-CW:0]        upper;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lo_p_d[k] = $signed({1'b0, coord_i[k][LW-1:0]}) * weight_i[k];
      hi_p_d[k] = $signed(coord_i[k][CW-1:LW]) * weight_i[k];
      term_d[k] = $signed({hi_p_q[k], {LW{1'b0}}})
                + $signed({{(HW-1){lo_p_q[k][LPW-1]}}, lo_p_q[k]});
    end
  end

  always_comb begin
    acc_d = $signed({{2{term_q[0][PW-1]}}, term_q[0]})
          + $signed({{2{term_q[1][PW-1]}}, term_q[1]})
          + $signed({{2{term_q[2][PW-1]}}, term_q[2]})
          + $signed({{2{term_q[3][PW-1]}}, term_q[3]});
  end

  always_comb begin
    shifted = (acc_q + Half) >>> (T_FRAC_BITS + 1);
    upper   = shifted[AW-1:CW-1];
    if ((&upper) || !(|upper)) begin
      result_d = shifted[CW-1:0];
      clip_d   = 1'b0;
    end else begin
      result_d = shifted[AW-1] ? MinV : MaxV;
      clip_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      lo_p_q <= lo_p_d;
      hi_p_q <= hi_p_d;
    end
    if (en_i.comb) begin
      term_q <= term_d;
    end
    if (en_i.sum) begin
      acc_q <= acc_d;
    end
    if (en_i.fin) begin
      result_q <= result_d;
      clip_q   <= clip_d;
    end
  end

  assign result_o = result_q;
  assign clip_o   = clip_q;

endmodule

// ===== hdl/catmull_rom_point_gradient_unit.sv =====
// Top level of the uniform 2D Catmull-Rom point and gradient unit.
// Usage: the input channel carries one word per curve sample: mode_i, the
// parameter t_param_i in unsigned Q1.F and the four control points prev,
// from, to and next as signed fixed-point x and y. A word is taken at a
// rising edge where in_valid_i is high and in_stall_o is low. Mode 0 gives
// the curve point, mode 1 the derivative with respect to t. A t above 1.0
// is treated as 1.0.
// The output channel presents out_x_o, out_y_o and clipped_o with
// out_valid_o; the word moves at an edge where out_stall_i is low.
// There are seven register stages: t squared, t cubed, weights, split
// products, product recombination, four-term sum, rounding and saturation.
// Throughput is one word per cycle while out_stall_i is low, limited by the
// single word per stage.
// When the receiver stalls, the stages fill up behind the output register;
// in_stall_o rises only once no stage can take another word.
// Reset empties the pipeline; it holds no other state.
module catmull_rom_point_gradient_unit #(
  parameter int unsigned COORD_WIDTH = crg_pkg::COORD_WIDTH_DEF,
  parameter int unsigned T_FRAC_BITS = crg_pkg::T_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic [T_FRAC_BITS:0]          t_param_i,
  input  logic signed [COORD_WIDTH-1:0] prev_x_i,
  input  logic signed [COORD_WIDTH-1:0] prev_y_i,
  input  logic signed [COORD_WIDTH-1:0] from_x_i,
  input  logic signed [COORD_WIDTH-1:0] from_y_i,
  input  logic signed [COORD_WIDTH-1:0] to_x_i,
  input  logic signed [COORD_WIDTH-1:0] to_y_i,
  input  logic signed [COORD_WIDTH-1:0] next_x_i,
  input  logic signed [COORD_WIDTH-1:0] next_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] out_x_o,
  output logic signed [COORD_WIDTH-1:0] out_y_o,
  output logic                          clipped_o
);
  import crg_pkg::*;

  localparam int unsigned CW     = COORD_WIDTH;
  localparam int unsigned F      = T_FRAC_BITS;
  localparam int unsigned TW     = F + 1;
  localparam int unsigned SqW    = 2 * TW;
  localparam int unsigned WW     = F + 4;
  localparam int unsigned WX     = F + 6;
  localparam int unsigned Stages = 7;

  localparam logic [TW-1:0]        OneT = TW'(1) << F;
  localparam logic [SqW-1:0]       Rnd  = SqW'(1) << (F - 1);
  localparam logic signed [WX-1:0] OneX = WX'(1) << F;
  localparam logic signed [CW-1:0] MaxV = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MinV = {1'b1, {(CW-1){1'b0}}};

  logic [Stages:1] v_q;
  logic [Stages:1] en;

  logic [TW-1:0]  t_c;
  logic [SqW-1:0] sq;
  logic [SqW-1:0] cu;

  logic           mode1_q, mode2_q;
  logic [TW-1:0]  t1_q, t2sq1_q;
  logic [TW-1:0]  t2_q, t2sq2_q, t3_q;

  logic signed [CW-1:0] pts_in [8];
  logic signed [CW-1:0] pts1_q [8];
  logic signed [CW-1:0] pts2_q [8];
  logic signed [CW-1:0] pts3_q [8];

  logic signed [WX-1:0] tx, t2x, t3x;
  logic signed [WX-1:0] wx   [4];
  logic signed [WW-1:0] w3_q [4];

  logic signed [CW-1:0] cx [4];
  logic signed [CW-1:0] cy [4];
  logic                 clip_x, clip_y;
  crg_en_t              lane_en;

  always_comb begin
    en[Stages] = !v_q[Stages] || !out_stall_i;
    for (int k = Stages - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= in_valid_i;
      for (int k = 2; k <= Stages; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_comb begin
    pts_in[0] = prev_x_i;
    pts_in[1] = prev_y_i;
    pts_in[2] = from_x_i;
    pts_in[3] = from_y_i;
    pts_in[4] = to_x_i;
    pts_in[5] = to_y_i;
    pts_in[6] = next_x_i;
    pts_in[7] = next_y_i;
    t_c = (t_param_i > OneT) ? OneT : t_param_i;
    sq  = SqW'(t_c * t_c) + Rnd;
    cu  = SqW'(t2sq1_q * t1_q) + Rnd;
  end

  always_comb begin
    tx  = $signed(WX'(t2_q));
    t2x = $signed(WX'(t2sq2_q));
    t3x = $signed(WX'(t3_q));
    if (!mode2_q) begin
      wx[0] = (t2x <<< 1) - t3x - tx;
      wx[1] = (t3x <<< 1) + t3x - (t2x <<< 2) - t2x + (OneX <<< 1);
      wx[2] = (t2x <<< 2) + tx - (t3x <<< 1) - t3x;
      wx[3] = t3x - t2x;
    end else begin
      wx[0] = (tx <<< 2) - (t2x <<< 1) - t2x - OneX;
      wx[1] = (t2x <<< 3) + t2x - (tx <<< 3) - (tx <<< 1);
      wx[2] = (tx <<< 3) + OneX - (t2x <<< 3) - t2x;
      wx[3] = (t2x <<< 1) + t2x - (tx <<< 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      mode1_q <= mode_i;
      t1_q    <= t_c;
      t2sq1_q <= sq[F +: TW];
      pts1_q  <= pts_in;
    end
    if (en[2]) begin
      mode2_q <= mode1_q;
      t2_q    <= t1_q;
      t2sq2_q <= t2sq1_q;
      t3_q    <= cu[F +: TW];
      pts2_q  <= pts1_q;
    end
    if (en[3]) begin
      for (int k = 0; k < 4; k++) begin
        w3_q[k] <= wx[k][WW-1:0];
      end
      pts3_q <= pts2_q;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cx[k] = pts3_q[2*k];
      cy[k] = pts3_q[2*k+1];
    end
    lane_en.mul  = en[4];
    lane_en.comb = en[5];
    lane_en.sum  = en[6];
    lane_en.fin  = en[7];
  end

  crg_lane #(
    .COORD_WIDTH(COORD_WIDTH),
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_lane_x (
    .clk_i   (clk_i),
    .en_i    (lane_en),
    .coord_i (cx),
    .weight_i(w3_q),
    .result_o(out_x_o),
    .clip_o  (clip_x)
  );

  crg_lane #(
    .COORD_WIDTH(COORD_WIDTH),
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_lane_y (
    .clk_i   (clk_i),
    .en_i    (lane_en),
    .coord_i (cy),
    .weight_i(w3_q),
    .result_o(out_y_o),
    .clip_o  (clip_y)
  );

  assign out_valid_o = v_q[Stages];
  assign clipped_o   = clip_x | clip_y;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && (&v_q)))
    else $error("input stalled while the pipeline has room");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[1])
    else $error("accepted word did not enter the first stage");

  a_clip_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o) |->
      (out_x_o == MaxV || out_x_o == MinV || out_y_o == MaxV || out_y_o == MinV))
    else $error("clipped flag without a saturated coordinate");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_x_o) && $stable(out_y_o)))
    else $error("stalled result changed");
`endif

endmodule

// ===== tb/crg_sample_checker.sv =====
`timescale 1ns / 100ps
// Checker that predicts and compares every output word of the Catmull-Rom point and gradient unit.
module crg_sample_checker #(
  parameter int unsigned CW = crg_pkg::COORD_WIDTH_DEF,
  parameter int unsigned TF = crg_pkg::T_FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 mode_i,
  input  logic [TF:0]          t_param_i,
  input  logic signed [CW-1:0] prev_x_i,
  input  logic signed [CW-1:0] prev_y_i,
  input  logic signed [CW-1:0] from_x_i,
  input  logic signed [CW-1:0] from_y_i,
  input  logic signed [CW-1:0] to_x_i,
  input  logic signed [CW-1:0] to_y_i,
  input  logic signed [CW-1:0] next_x_i,
  input  logic signed [CW-1:0] next_y_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic signed [CW-1:0] out_x_i,
  input  logic signed [CW-1:0] out_y_i,
  input  logic                 clipped_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 clipped;
  } sample_t;

  sample_t     expected_samples[$];
  sample_t     seen;
  sample_t     want;
  int unsigned fail_count = 0;

  // Points are ordered prev, from, to and next, with x before y for each.
  function automatic sample_t spline_sample(input logic mode, input logic [TF:0] t_raw,
                                            input logic signed [CW-1:0] pts [8]);
    longint              one;
    longint              rnd;
    longint              t;
    longint              t2;
    longint              t3;
    longint              w [4];
    logic signed [127:0] acc;
    logic signed [127:0] term_c;
    logic signed [127:0] term_w;
    logic signed [127:0] lim_hi;
    logic signed [127:0] lim_lo;
    sample_t             r;
    int                  c;
    int                  k;
    one = longint'(1) << TF;
    rnd = longint'(1) << (TF - 1);
    t = longint'(t_raw);
    if (t > one) t = one;
    t2 = (t * t + rnd) >>> TF;
    t3 = (t2 * t + rnd) >>> TF;
    if (!mode) begin
      w[0] = -t3 + 2 * t2 - t;
      w[1] = 3 * t3 - 5 * t2 + 2 * one;
      w[2] = -3 * t3 + 4 * t2 + t;
      w[3] = t3 - t2;
    end else begin
      w[0] = -3 * t2 + 4 * t - one;
      w[1] = 9 * t2 - 10 * t;
      w[2] = -9 * t2 + 8 * t + one;
      w[3] = 3 * t2 - 2 * t;
    end
    lim_hi = (128'sd1 <<< (CW - 1)) - 128'sd1;
    lim_lo = -lim_hi - 128'sd1;
    r = '0;
    for (c = 0; c < 2; c++) begin
      acc = '0;
      for (k = 0; k < 4; k++) begin
        term_c = pts[2 * k + c];
        term_w = w[k];
        acc = acc + term_c * term_w;
      end
      acc = (acc + (128'sd1 <<< TF)) >>> (TF + 1);
      if (acc > lim_hi) begin
        acc = lim_hi;
        r.clipped = 1'b1;
      end else if (acc < lim_lo) begin
        acc = lim_lo;
        r.clipped = 1'b1;
      end
      if (c == 0) r.x = acc[CW-1:0];
      else r.y = acc[CW-1:0];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_samples.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_samples.push_back(spline_sample(mode_i, t_param_i,
            '{prev_x_i, prev_y_i, from_x_i, from_y_i, to_x_i, to_y_i, next_x_i, next_y_i}));
      end
      if (out_valid_i && !out_stall_i) begin
        seen.x = out_x_i;
        seen.y = out_y_i;
        seen.clipped = clipped_i;
        if (expected_samples.size() == 0) begin
          if (fail_count < 10) begin
            $display("%0t: unexpected word x %h y %h clipped %b", $time, seen.x, seen.y,
                     seen.clipped);
          end
          fail_count++;
        end else begin
          want = expected_samples.pop_front();
          if (seen.x !== want.x || seen.y !== want.y || seen.clipped !== want.clipped) begin
            if (fail_count < 10) begin
              $display("%0t: mismatch x exp %h got %h, y exp %h got %h, clipped exp %b got %b",
                       $time, want.x, seen.x, want.y, seen.y, want.clipped, seen.clipped);
            end
            fail_count++;
          end
        end
      end
    end
    pending_o <= expected_samples.size();
    fail_count_o <= fail_count;
  end

endmodule

// ===== tb/tb_catmull_rom_point_gradient_unit.sv =====
`timescale 1ns / 100ps
// Testbench top of the Catmull-Rom point and gradient unit: stimulus, receiver stalls, verdict.
module tb_catmull_rom_point_gradient_unit;
  import crg_pkg::*;

  localparam int unsigned CW = COORD_WIDTH_DEF;
  localparam int unsigned TF = T_FRAC_BITS_DEF;
  localparam int unsigned ONE = 1 << TF;
  localparam int unsigned RANDOM_WORDS = 1400;
  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW - 1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW - 1){1'b0}}};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 mode = 1'b0;
  logic [TF:0]          t_param = '0;
  logic signed [CW-1:0] prev_x = '0;
  logic signed [CW-1:0] prev_y = '0;
  logic signed [CW-1:0] from_x = '0;
  logic signed [CW-1:0] from_y = '0;
  logic signed [CW-1:0] to_x = '0;
  logic signed [CW-1:0] to_y = '0;
  logic signed [CW-1:0] next_x = '0;
  logic signed [CW-1:0] next_y = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [CW-1:0] out_x;
  logic signed [CW-1:0] out_y;
  logic                 clipped;
  int unsigned          fail_count;
  int unsigned          pending;
  int unsigned          sent = 0;
  logic                 send_quiet = 1'b0;
  logic                 recv_quiet = 1'b0;

  catmull_rom_point_gradient_unit i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .mode_i     (mode),
    .t_param_i  (t_param),
    .prev_x_i   (prev_x),
    .prev_y_i   (prev_y),
    .from_x_i   (from_x),
    .from_y_i   (from_y),
    .to_x_i     (to_x),
    .to_y_i     (to_y),
    .next_x_i   (next_x),
    .next_y_i   (next_y),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_x_o    (out_x),
    .out_y_o    (out_y),
    .clipped_o  (clipped)
  );

  crg_sample_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .mode_i      (mode),
    .t_param_i   (t_param),
    .prev_x_i    (prev_x),
    .prev_y_i    (prev_y),
    .from_x_i    (from_x),
    .from_y_i    (from_y),
    .to_x_i      (to_x),
    .to_y_i      (to_y),
    .next_x_i    (next_x),
    .next_y_i    (next_y),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_x_i     (out_x),
    .out_y_i     (out_y),
    .clipped_i   (clipped),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_sample(input logic m, input int unsigned t,
                             input logic signed [CW-1:0] p [8]);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mode <= m;
    t_param <= (TF + 1)'(t);
    prev_x <= p[0];
    prev_y <= p[1];
    from_x <= p[2];
    from_y <= p[3];
    to_x <= p[4];
    to_y <= p[5];
    next_x <= p[6];
    next_y <= p[7];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
    if (sent % 50 == 0) send_quiet = ($urandom_range(0, 3) == 0);
  endtask

  function automatic logic signed [CW-1:0] random_coord();
    logic signed [CW-1:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      3: r = r >>> $urandom_range(4, 24);
      4: r = COORD_MAX;
      5: r = COORD_MIN;
      6: r = CW'($urandom_range(0, 2)) - 1'b1;
      7: r = r[0] ? COORD_MAX - $urandom_range(0, 255) : COORD_MIN + $urandom_range(0, 255);
      default: ;
    endcase
    return r;
  endfunction

  // Most words are plausible curve segments; the rest use arbitrary and extreme points.
  task automatic send_random_sample();
    logic signed [CW-1:0] pts [8];
    logic signed [CW-1:0] base;
    logic signed [CW-1:0] step;
    logic signed [CW-1:0] jitter;
    int unsigned          t;
    int                   style;
    int                   c;
    int                   k;
    style = $urandom_range(0, 9);
    for (c = 0; c < 2; c++) begin
      base = $urandom;
      base = base >>> 2;
      step = $urandom;
      step = step >>> $urandom_range(6, 20);
      for (k = 0; k < 4; k++) begin
        jitter = $urandom;
        jitter = jitter >>> 20;
        if (style < 6) pts[2 * k + c] = base + step * k + jitter;
        else pts[2 * k + c] = random_coord();
      end
    end
    case ($urandom_range(0, 9))
      0: t = ONE;
      1: t = 0;
      2: t = $urandom_range(ONE + 1, 2 * ONE - 1);
      default: t = $urandom_range(0, ONE);
    endcase
    send_sample(1'($urandom_range(0, 1)), t, pts);
  endtask

  task automatic send_directed_samples();
    send_sample(1'b0, '0, '{default: '0});
    send_sample(1'b0, ONE, '{default: COORD_MAX});
    send_sample(1'b0, '0, '{default: COORD_MIN});
    send_sample(1'b1, ONE, '{default: COORD_MAX});
    send_sample(1'b1, '0, '{default: COORD_MIN});
    send_sample(1'b0, 2 * ONE - 1, '{1, -3, 65536, 7, -65536, 11, 13, -17});
    send_sample(1'b1, ONE + 1, '{1, -3, 65536, 7, -65536, 11, 13, -17});
    send_sample(1'b0, ONE / 2,
                '{COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN,
                  COORD_MAX});
    send_sample(1'b1, ONE / 2,
                '{COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX,
                  COORD_MIN});
    send_sample(1'b1, '0,
                '{COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX,
                  COORD_MIN});
    send_sample(1'b1, ONE, '{5, COORD_MIN, -5, COORD_MAX, 9, COORD_MAX, -9, COORD_MIN});
    send_sample(1'b0, ONE / 2, '{0, 0, 1, -1, 0, 0, 0, 0});
    send_sample(1'b0, 1, '{-1, 1, -1, 1, 3, -3, 1, -1});
    send_sample(1'b1, ONE - 1, '{-1, 1, -1, 1, 3, -3, 1, -1});
    send_sample(1'b0, ONE / 3,
                '{32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555,
                  32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555});
    send_sample(1'b1, 3 * ONE / 4,
                '{32'shAAAA_AAAA, 32'sh5555_5555, 32'sh5555_5555, 32'shAAAA_AAAA,
                  32'shAAAA_AAAA, 32'sh5555_5555, 32'sh5555_5555, 32'shAAAA_AAAA});
    send_sample(1'b0, ONE / 4, '{-65536, 0, 0, 65536, 65536, 131072, 196608, 65536});
    send_sample(1'b1, ONE / 4, '{-65536, 0, 0, 65536, 65536, 131072, 196608, 65536});
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_directed_samples();
    repeat (RANDOM_WORDS) send_random_sample();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // The receiver may stall before each word; twice it holds off long enough to back up the whole pipeline.
  initial begin
    int hold;
    int received;
    received = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (received == 30 || received == 700) begin
        out_stall <= 1'b1;
        repeat (80) @(posedge clk);
      end
      hold = recv_quiet ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      received++;
      if (received % 50 == 0) recv_quiet = ($urandom_range(0, 3) == 0);
    end
  end

endmodule
